// ===== hw/rtl/msc_pkg.sv =====
// shared types, constants and lookup functions for the seven-segment counter
package msc_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int PLACE_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int COUNT_W    = 14;
   localparam int STEP_W     = 14;
   localparam int LOAD_W     = 16;
   localparam int SEG_W      = 7;
   localparam int SEL_W      = 4;
   localparam int DIGIT_W    = 4;
   localparam int RECIP_W    = 17;
   localparam int SHIFT_W    = 5;
   localparam int PROD_W     = COUNT_W + RECIP_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(9999);

   typedef enum logic [1:0] {
      CMD_SCAN = 2'd0,
      CMD_INC  = 2'd1,
      CMD_DEC  = 2'd2,
      CMD_LOAD = 2'd3
   } cmd_type;

   // floor(x / 10^p) = (x * mult) >> shift, exact for any 14-bit x and p up to 3
   typedef struct packed {
      logic [RECIP_W-1:0] mult;
      logic [SHIFT_W-1:0] shift;
   } recip_type;

   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [SEL_W-1:0] sel_n;
   } disp_type;

   function automatic recip_type place_recip(input logic [PLACE_W:0] place);
      recip_type r;
      case (place)
         (PLACE_W+1)'(0): begin r.mult = RECIP_W'(1);     r.shift = SHIFT_W'(0);  end
         (PLACE_W+1)'(1): begin r.mult = RECIP_W'(52429); r.shift = SHIFT_W'(19); end
         (PLACE_W+1)'(2): begin r.mult = RECIP_W'(5243);  r.shift = SHIFT_W'(19); end
         (PLACE_W+1)'(3): begin r.mult = RECIP_W'(16778); r.shift = SHIFT_W'(24); end
         // places past the thousands always hold zero
         default: begin r.mult = '0; r.shift = '0; end
      endcase
      return r;
   endfunction

   function automatic logic [SEG_W-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] p;
      case (d)
         4'd0:    p = 7'h3F;
         4'd1:    p = 7'h06;
         4'd2:    p = 7'h5B;
         4'd3:    p = 7'h4F;
         4'd4:    p = 7'h66;
         4'd5:    p = 7'h6D;
         4'd6:    p = 7'h7D;
         4'd7:    p = 7'h07;
         4'd8:    p = 7'h7F;
         4'd9:    p = 7'h6F;
         default: p = 7'h00;
      endcase
      return p;
   endfunction

   // place 0 drives the top select bit, places past the last position select nothing
   function automatic logic [SEL_W-1:0] select_for_place(input logic [PLACE_W-1:0] place);
      logic [SEL_W-1:0] s;
      s = '1;
      for (int i = 0; i < SEL_W; i++) begin
         if (int'(place) == SEL_W - 1 - i) begin
            s[i] = 1'b0;
         end
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/msc_if.sv =====
// valid/ready channel interfaces for requests and responses
interface msc_req_if
   import msc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [1:0]               cmd;
   logic [STEP_W-1:0]        step_amount;
   logic signed [LOAD_W-1:0] load_value;

   modport source (output valid, output cmd, output step_amount, output load_value,
                   input ready);
   modport sink   (input valid, input cmd, input step_amount, input load_value,
                   output ready);
endinterface

interface msc_rsp_if
   import msc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [SEG_W-1:0]   segment_drive;
   logic [SEL_W-1:0]   digit_select_n;
   logic [COUNT_W-1:0] count_value;

   modport source (output valid, output segment_drive, output digit_select_n,
                   output count_value, input ready);
   modport sink   (input valid, input segment_drive, input digit_select_n,
                   input count_value, output ready);
endinterface

// ===== hw/rtl/msc_digit.sv =====
// decimal digit extraction and segment/select decode for one scan place
module msc_digit
   import msc_pkg::*;
(
   input  logic [COUNT_W-1:0] count,
   input  logic [PLACE_W-1:0] place,
   output disp_type           disp
);

   recip_type          recip_a;
   recip_type          recip_b;
   logic [PROD_W-1:0]  prod_a;
   logic [PROD_W-1:0]  prod_b;
   logic [COUNT_W-1:0] quot_a;
   logic [COUNT_W-1:0] quot_b;
   logic [COUNT_W-1:0] rem;

   assign recip_a = place_recip({1'b0, place});
   assign recip_b = place_recip({1'b0, place} + (PLACE_W+1)'(1));

   assign prod_a = PROD_W'(count) * PROD_W'(recip_a.mult);
   assign prod_b = PROD_W'(count) * PROD_W'(recip_b.mult);

   assign quot_a = COUNT_W'(prod_a >> recip_a.shift);
   assign quot_b = COUNT_W'(prod_b >> recip_b.shift);

   // digit = quot_a - 10 * quot_b
   assign rem = quot_a - (quot_b << 3) - (quot_b << 1);

   assign disp.seg   = digit_pattern(rem[DIGIT_W-1:0]);
   assign disp.sel_n = select_for_place(place);

endmodule

// ===== hw/rtl/msc_update.sv =====
// next count for increment, decrement and clamped load
module msc_update
   import msc_pkg::*;
(
   input  logic [COUNT_W-1:0]        count,
   input  cmd_type                   cmd,
   input  logic [STEP_W-1:0]         step_amount,
   input  logic signed [LOAD_W-1:0]  load_value,
   output logic [COUNT_W-1:0]        count_next
);

   logic [COUNT_W:0] sum;

   assign sum = {1'b0, count} + (COUNT_W+1)'(step_amount);

   always_comb begin
      count_next = count;
      case (cmd)
         CMD_INC: begin
            if (sum <= {1'b0, COUNT_MAX}) begin
               count_next = sum[COUNT_W-1:0];
            end
         end
         CMD_DEC: begin
            if (count >= step_amount) begin
               count_next = count - step_amount;
            end
         end
         CMD_LOAD: begin
            if (load_value >= $signed({2'b00, COUNT_MAX})) begin
               count_next = COUNT_MAX;
            end else if (load_value <= 0) begin
               count_next = '0;
            end else begin
               count_next = load_value[COUNT_W-1:0];
            end
         end
         default: count_next = count;
      endcase
   end

endmodule

// ===== hw/rtl/multiplexed_seven_segment_counter.sv =====
// a request passes the input register, then the state registers that hold the response
// one request per cycle unless the response stalls; update and digit split share one stage
// the state registers double as the response register, so they hold while a response stalls
// a stalled response still lets one more request into the input register
// reset (synchronous, active high): count 0, scan place 0, segments off, no digit selected
module multiplexed_seven_segment_counter
   import msc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   msc_req_if.sink    req,
   msc_rsp_if.source  rsp
);

   logic                     in_valid_ff, in_valid_in;
   cmd_type                  cmd_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [LOAD_W-1:0] load_ff;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PLACE_W-1:0] place_ff, place_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [SEL_W-1:0]   sel_ff, sel_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               advance;
   logic [COUNT_W-1:0] count_next;
   disp_type           disp;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire = req.valid && req.ready;

   msc_update u_update (
      .count       (count_ff),
      .cmd         (cmd_ff),
      .step_amount (step_ff),
      .load_value  (load_ff),
      .count_next  (count_next)
   );

   msc_digit u_digit (
      .count (count_ff),
      .place (place_ff),
      .disp  (disp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      count_in = count_ff;
      place_in = place_ff;
      seg_in   = seg_ff;
      sel_in   = sel_ff;
      if (advance) begin
         if (cmd_ff == CMD_SCAN) begin
            seg_in = disp.seg;
            sel_in = disp.sel_n;
            if (place_ff == PLACE_W'(NUM_DIGITS - 1)) begin
               place_in = '0;
            end else begin
               place_in = place_ff + PLACE_W'(1);
            end
         end else begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         place_ff     <= '0;
         seg_ff       <= '0;
         sel_ff       <= '1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         place_ff     <= place_in;
         seg_ff       <= seg_in;
         sel_ff       <= sel_in;
      end
   end

   // request payload loads only on an accepted request, gated by req_fire
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= cmd_type'(req.cmd);
         step_ff <= req.step_amount;
         load_ff <= req.load_value;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.segment_drive  = seg_ff;
   assign rsp.digit_select_n = sel_ff;
   assign rsp.count_value    = count_ff;

endmodule
